// ----- rtl/dalt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allowlist table package
// Shared types and codes for the learning allowlist table.
// ----------------------------------------------------------------------------
package dalt_pkg;

    localparam int ADDR_W  = 16;
    localparam int HASH_W  = 32;
    localparam int FLAGS_W = 16;
    localparam int CNT_W   = 32;
    localparam int DEVC_W  = 5;
    localparam int MODE_W  = 2;
    localparam int FUNC_W  = 2;
    localparam int CFGI_W  = 1;
    localparam int CFGD_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_AUTH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEARN = 2'd1;

    localparam logic [CFGI_W-1:0] CFG_AUTH_MODE = 1'd0;
    localparam logic [CFGI_W-1:0] CFG_ENABLED   = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [HASH_W-1:0]  hash;
        logic [FLAGS_W-1:0] flags;
    } t_entry;

endpackage
`default_nettype wire

// ----- rtl/device_allowlist_learning_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Learning allowlist table
// Device table with authorize, add and remove operations, transfer counters
// and an entry count.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the input channel (i_in_valid / o_in_ready) and each one
// yields exactly one result on the output channel (o_out_valid / i_out_ready).
// The entries live in a synchronous memory with a registered read; valid bits
// are flip-flops. Each item sweeps every entry through the single read port,
// one entry a cycle, to find the first matching entry and the first free one,
// then writes back at most once.
// The sweep over the read port sets the pace: an item is taken only while the
// table is idle, so the next item waits until the current one has finished
// its sweep and reached its result.
// The next item is accepted while a result still waits in the output
// register; if the receiver stalls, the following item holds before its
// write-back until that result is taken.
// Reset clears all valid bits, both counters, the configuration registers and
// the output register at once; no clearing pass is needed.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
// ----------------------------------------------------------------------------
module device_allowlist_learning_table
    import dalt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [CFGI_W-1:0]   i_cfg_index,
    input  wire  [CFGD_W-1:0]   i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [FUNC_W-1:0]   i_func,
    input  wire  [ADDR_W-1:0]   i_address,
    input  wire  [HASH_W-1:0]   i_mac_hash,
    input  wire                 i_hash_present,
    input  wire  [FLAGS_W-1:0]  i_flags,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_ok,
    output logic [CNT_W-1:0]    o_success_total,
    output logic [CNT_W-1:0]    o_fail_total,
    output logic [DEVC_W-1:0]   o_device_count
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    t_entry              mem [TABLE_ENTRIES];
    t_entry              r_rd_data;

    t_state              r_state;
    t_state              n_state;

    logic [MODE_W-1:0]   r_mode;
    logic                r_en;

    logic [FUNC_W-1:0]   r_func;
    logic [ADDR_W-1:0]   r_addr;
    logic [HASH_W-1:0]   r_hash;
    logic                r_hp;
    logic [FLAGS_W-1:0]  r_flags;

    logic                r_issue;
    logic [IW-1:0]       r_idx;
    logic                r_pend;
    logic [IW-1:0]       r_pidx;
    logic                r_hit;
    logic [IW-1:0]       r_hit_idx;
    logic [HASH_W-1:0]   r_hit_hash;
    logic                r_free;
    logic [IW-1:0]       r_free_idx;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [CW-1:0]       r_count;
    logic [CNT_W-1:0]    r_succ;
    logic [CNT_W-1:0]    r_fail;
    logic                r_out_valid;
    logic                r_ok;

    logic                in_fire;
    logic                done_fire;
    logic                scan_end;
    logic                wr_en;
    logic [IW-1:0]       wr_idx;
    t_entry              wr_data;
    logic                set_valid;
    logic                clr_valid;
    logic                ok;
    logic                inc_succ;
    logic                inc_fail;
    logic [31:0]         cnt_ext;

    assign scan_end = r_pend && (r_pidx == LAST_IDX);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        done_fire  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_SCAN: o_in_ready = 1'b0;
            ST_DONE: done_fire  = !r_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign in_fire = i_in_valid && o_in_ready;

    always_comb begin
        wr_en     = 1'b0;
        wr_idx    = r_free_idx;
        wr_data   = '{address: r_addr, hash: (r_hp ? r_hash : '0), flags: '0};
        set_valid = 1'b0;
        clr_valid = 1'b0;
        ok        = 1'b0;
        inc_succ  = 1'b0;
        inc_fail  = 1'b0;
        unique case (r_func)
            FUNC_AUTH: begin
                if (r_en) begin
                    if (r_mode == MODE_OPEN) begin
                        ok = 1'b1;
                    end else if (r_hit) begin
                        ok = !r_hp || (r_hit_hash == r_hash);
                    end else if (r_mode == MODE_LEARN && r_free) begin
                        wr_en     = 1'b1;
                        set_valid = 1'b1;
                        ok        = 1'b1;
                    end
                    inc_succ = ok;
                    inc_fail = !ok;
                end
            end
            FUNC_ADD: begin
                wr_data.flags = r_flags;
                if (r_hit) begin
                    wr_en        = 1'b1;
                    wr_idx       = r_hit_idx;
                    wr_data.hash = r_hp ? r_hash : r_hit_hash;
                    ok           = 1'b1;
                end else if (r_free) begin
                    wr_en     = 1'b1;
                    set_valid = 1'b1;
                    ok        = 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (r_hit) begin
                    clr_valid = 1'b1;
                    ok        = 1'b1;
                end
            end
            default: ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_idx];
        if (done_fire && wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func  <= i_func;
            r_addr  <= i_address;
            r_hash  <= i_mac_hash;
            r_hp    <= i_hash_present;
            r_flags <= i_flags;
        end
        r_pidx <= r_idx;
        if (r_pend) begin
            if (!r_hit && r_valid[r_pidx] && (r_rd_data.address == r_addr)) begin
                r_hit_idx  <= r_pidx;
                r_hit_hash <= r_rd_data.hash;
            end
            if (!r_free && !r_valid[r_pidx]) begin
                r_free_idx <= r_pidx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_OPEN;
            r_en        <= 1'b0;
            r_issue     <= 1'b0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_succ      <= '0;
            r_fail      <= '0;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_AUTH_MODE: r_mode <= i_cfg_data;
                    CFG_ENABLED:   r_en   <= i_cfg_data[0];
                    default:       r_en   <= r_en;
                endcase
            end
            r_pend <= r_issue;
            if (in_fire) begin
                r_issue <= 1'b1;
                r_idx   <= '0;
                r_hit   <= 1'b0;
                r_free  <= 1'b0;
            end else if (r_issue) begin
                if (r_idx == LAST_IDX) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (r_pend) begin
                if (r_valid[r_pidx] && (r_rd_data.address == r_addr)) begin
                    r_hit <= 1'b1;
                end
                if (!r_valid[r_pidx]) begin
                    r_free <= 1'b1;
                end
            end
            if (done_fire) begin
                r_out_valid <= 1'b1;
                r_ok        <= ok;
                if (set_valid) begin
                    r_valid[wr_idx] <= 1'b1;
                    r_count         <= r_count + 1'b1;
                end
                if (clr_valid) begin
                    r_valid[r_hit_idx] <= 1'b0;
                    r_count            <= r_count - 1'b1;
                end
                if (inc_succ) begin
                    r_succ <= r_succ + 1'b1;
                end
                if (inc_fail) begin
                    r_fail <= r_fail + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign cnt_ext = 32'(r_count);

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_success_total = r_succ;
    assign o_fail_total    = r_fail;
    assign o_device_count  = (cnt_ext > 32'd31) ? 5'd31 : cnt_ext[DEVC_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/dalt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allowlist table checker
// Port-level properties of the learning allowlist table.
// ----------------------------------------------------------------------------
module dalt_checker
    import dalt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input wire                 o_ok,
    input wire [CNT_W-1:0]     o_success_total,
    input wire [CNT_W-1:0]     o_fail_total,
    input wire [DEVC_W-1:0]    o_device_count
);

    localparam logic [DEVC_W:0] MAX_COUNT =
        (TABLE_ENTRIES > 31) ? 6'd31 : 6'(TABLE_ENTRIES);

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again while an item is in work");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_success_total == '0 && o_fail_total == '0
                      && o_device_count == '0))
        else $error("result or state left over after reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_device_count} <= MAX_COUNT))
        else $error("device count exceeds the table size");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_ok) && $stable(o_success_total)
             && $stable(o_fail_total) && $stable(o_device_count)))
        else $error("stalled result changed");

endmodule

bind device_allowlist_learning_table dalt_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
) u_dalt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_ok           (o_ok),
    .o_success_total(o_success_total),
    .o_fail_total   (o_fail_total),
    .o_device_count (o_device_count)
);
`default_nettype wire
